// ===== rtl/core/coap_pkg.sv =====
package coap_pkg;

    typedef enum logic [2:0] {
        PH_HEADER  = 3'd0,
        PH_TOKEN   = 3'd1,
        PH_OPTHDR  = 3'd2,
        PH_DEXT    = 3'd3,
        PH_LEXT    = 3'd4,
        PH_VALUE   = 3'd5,
        PH_PAYLOAD = 3'd6,
        PH_IGNORE  = 3'd7
    } t_phase;

    localparam logic [2:0] CLS_HEADER  = 3'd0;
    localparam logic [2:0] CLS_TOKEN   = 3'd1;
    localparam logic [2:0] CLS_OPTHDR  = 3'd2;
    localparam logic [2:0] CLS_EXT     = 3'd3;
    localparam logic [2:0] CLS_VALUE   = 3'd4;
    localparam logic [2:0] CLS_MARKER  = 3'd5;
    localparam logic [2:0] CLS_PAYLOAD = 3'd6;
    localparam logic [2:0] CLS_IGNORE  = 3'd7;

    localparam int ERR_FORMAT  = 0;
    localparam int ERR_VERSION = 1;
    localparam int ERR_TOKEN   = 2;
    localparam int ERR_MARKER  = 3;
    localparam int ERR_TRUNC   = 4;

    localparam logic [7:0]  MARKER_BYTE = 8'hff;
    localparam logic [3:0]  NIB_EXT8    = 4'd13;
    localparam logic [3:0]  NIB_EXT16   = 4'd14;
    localparam logic [3:0]  NIB_RSVD    = 4'd15;
    localparam logic [16:0] EXT8_OFS    = 17'd13;
    localparam logic [16:0] EXT16_OFS   = 17'd269;
    localparam logic [1:0]  COAP_VER    = 2'd1;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last;
    } t_coap_in;

    typedef struct packed {
        logic [2:0]  byte_class;
        logic [7:0]  byte_out;
        logic [1:0]  version;
        logic [1:0]  msg_type;
        logic [3:0]  token_len;
        logic [7:0]  code;
        logic [15:0] msg_id;
        logic [15:0] option_number;
        logic [16:0] option_length;
        logic        end_of_message;
        logic [4:0]  errors;
    } t_coap_out;

endpackage

// ===== rtl/core/coap_message_parser.sv =====
// CoAP message parser.
// Input channel: one message byte per word (data_byte) with last set on the
// final byte of a message. Output channel: one result word per input byte
// carrying the byte class, the byte itself, the header fields seen so far,
// the current absolute option number and value length, end_of_message and
// the accumulated error flags of the message.
// Latency: a result is presented the cycle after its byte is accepted.
// Throughput: one byte per clock unless stalled; all parsing state is updated
// by a single pass of logic between the accepted byte and the output register.
// After a byte with last set, all parsing state returns to the header phase
// so the next byte starts a new message.
// Reset (synchronous, active low) clears the parsing state and empties the
// output register.
// When the receiver stalls, the output register holds its word and o_in_ready
// drops, so no further byte is taken until the held word is accepted.
module coap_message_parser #(
    parameter int MAX_TOKEN = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  coap_pkg::t_coap_in  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output coap_pkg::t_coap_out o_out_data
);
    import coap_pkg::*;

    logic        w_in_fire;
    logic [7:0]  w_b;
    logic        w_last;
    logic [2:0]  w_class;
    logic        w_hdr_end;
    logic [3:0]  w_lc_eff;
    logic [3:0]  w_ext_code;
    logic [15:0] w_acc_shift;
    logic [16:0] w_ext_val;
    logic [16:0] w_delta;
    logic [17:0] w_sum;

    t_phase      r_phase, n_phase;
    logic [1:0]  r_hdr_cnt, n_hdr_cnt;
    logic [3:0]  r_token_left, n_token_left;
    logic [1:0]  r_ext_left, n_ext_left;
    logic [3:0]  r_delta_code, n_delta_code;
    logic [3:0]  r_length_code, n_length_code;
    logic [15:0] r_ext_acc, n_ext_acc;
    logic [15:0] r_opt_num, n_opt_num;
    logic [16:0] r_value_left, n_value_left;
    logic [31:0] r_hdr, n_hdr;
    logic [4:0]  r_err, n_err;
    logic [16:0] r_cur_len, n_cur_len;

    logic        r_out_valid;
    t_coap_out   r_out;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign w_in_fire   = i_in_valid && o_in_ready;
    assign w_b         = i_in_data.data_byte;
    assign w_last      = i_in_data.last;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Shared extension path for delta and length extensions
    assign w_ext_code  = (r_phase == PH_DEXT) ? r_delta_code : r_length_code;
    assign w_acc_shift = {r_ext_acc[7:0], w_b};
    assign w_ext_val   = (w_ext_code == NIB_EXT8) ? ({9'd0, w_b} + EXT8_OFS)
                                                  : ({1'b0, w_acc_shift} + EXT16_OFS);
    assign w_lc_eff    = (r_phase == PH_OPTHDR) ? w_b[3:0] : r_length_code;
    assign w_delta     = (r_phase == PH_OPTHDR) ? {13'd0, w_b[7:4]} : w_ext_val;
    assign w_sum       = {2'b00, r_opt_num} + {1'b0, w_delta};

    // Next state
    always_comb begin
        logic do_add;
        logic do_len;
        logic [16:0] len_val;
        logic [3:0] tl_dec;
        logic [1:0] el_dec;
        logic [16:0] vl_dec;

        n_phase       = r_phase;
        n_hdr_cnt     = r_hdr_cnt;
        n_token_left  = r_token_left;
        n_ext_left    = r_ext_left;
        n_delta_code  = r_delta_code;
        n_length_code = r_length_code;
        n_ext_acc     = r_ext_acc;
        n_opt_num     = r_opt_num;
        n_value_left  = r_value_left;
        n_hdr         = r_hdr;
        n_err         = r_err;
        n_cur_len     = r_cur_len;
        w_hdr_end     = 1'b0;
        do_add        = 1'b0;
        do_len        = 1'b0;
        len_val       = 17'd0;
        tl_dec        = (r_token_left != 4'd0) ? r_token_left - 4'd1 : r_token_left;
        el_dec        = (r_ext_left != 2'd0) ? r_ext_left - 2'd1 : r_ext_left;
        vl_dec        = (r_value_left != 17'd0) ? r_value_left - 17'd1 : r_value_left;

        case (r_phase)
            PH_HEADER: begin
                case (r_hdr_cnt)
                    2'd0:    n_hdr[31:24] = r_hdr[31:24] | w_b;
                    2'd1:    n_hdr[23:16] = r_hdr[23:16] | w_b;
                    2'd2:    n_hdr[15:8]  = r_hdr[15:8]  | w_b;
                    default: n_hdr[7:0]   = r_hdr[7:0]   | w_b;
                endcase
                if (r_hdr_cnt == 2'd0) begin
                    if (w_b[7:6] != COAP_VER) n_err[ERR_VERSION] = 1'b1;
                    if (w_b[3:0] > 4'(MAX_TOKEN)) n_err[ERR_TOKEN] = 1'b1;
                end
                if (r_hdr_cnt == 2'd3) begin
                    w_hdr_end    = 1'b1;
                    n_token_left = r_hdr[27:24];
                    n_phase      = (r_hdr[27:24] != 4'd0) ? PH_TOKEN : PH_OPTHDR;
                    n_hdr_cnt    = 2'd0;
                end else begin
                    n_hdr_cnt = r_hdr_cnt + 2'd1;
                    if (w_last) n_err[ERR_FORMAT] = 1'b1;
                end
            end
            PH_TOKEN: begin
                n_token_left = tl_dec;
                if (tl_dec == 4'd0) n_phase = PH_OPTHDR;
            end
            PH_OPTHDR: begin
                if (w_b == MARKER_BYTE) begin
                    n_phase = PH_PAYLOAD;
                    if (w_last) n_err[ERR_MARKER] = 1'b1;
                end else begin
                    n_delta_code  = w_b[7:4];
                    n_length_code = w_b[3:0];
                    n_cur_len     = (w_b[3:0] < NIB_EXT8) ? {13'd0, w_b[3:0]} : 17'd0;
                    if (w_b[7:4] == NIB_RSVD || w_b[3:0] == NIB_RSVD) begin
                        n_err[ERR_MARKER] = 1'b1;
                        n_phase = PH_IGNORE;
                    end else if (w_b[7:4] >= NIB_EXT8) begin
                        n_phase    = PH_DEXT;
                        n_ext_left = (w_b[7:4] == NIB_EXT8) ? 2'd1 : 2'd2;
                        n_ext_acc  = 16'd0;
                    end else begin
                        do_add = 1'b1;
                    end
                end
            end
            PH_DEXT: begin
                n_ext_acc  = w_acc_shift;
                n_ext_left = el_dec;
                if (el_dec == 2'd0) do_add = 1'b1;
            end
            PH_LEXT: begin
                n_ext_acc  = w_acc_shift;
                n_ext_left = el_dec;
                if (el_dec == 2'd0) begin
                    do_len  = 1'b1;
                    len_val = w_ext_val;
                end
            end
            PH_VALUE: begin
                n_value_left = vl_dec;
                if (vl_dec == 17'd0) n_phase = PH_OPTHDR;
            end
            default: begin
            end
        endcase

        // Accumulate delta, saturate, then pick up the length
        if (do_add) begin
            if (w_sum > 18'd65535) begin
                n_opt_num = 16'hffff;
                n_err[ERR_FORMAT] = 1'b1;
            end else begin
                n_opt_num = w_sum[15:0];
            end
            if (w_lc_eff >= NIB_EXT8) begin
                n_phase    = PH_LEXT;
                n_ext_left = (w_lc_eff == NIB_EXT8) ? 2'd1 : 2'd2;
                n_ext_acc  = 16'd0;
            end else begin
                do_len  = 1'b1;
                len_val = {13'd0, w_lc_eff};
            end
        end
        if (do_len) begin
            n_cur_len    = len_val;
            n_value_left = len_val;
            n_phase      = (len_val != 17'd0) ? PH_VALUE : PH_OPTHDR;
        end

        if (w_last && (n_phase == PH_DEXT || n_phase == PH_LEXT || n_phase == PH_VALUE ||
                       (n_phase == PH_TOKEN && !w_hdr_end)))
            n_err[ERR_TRUNC] = 1'b1;
    end

    // Byte class
    always_comb begin
        case (r_phase)
            PH_HEADER:  w_class = CLS_HEADER;
            PH_TOKEN:   w_class = CLS_TOKEN;
            PH_OPTHDR:  w_class = (w_b == MARKER_BYTE) ? CLS_MARKER : CLS_OPTHDR;
            PH_DEXT:    w_class = CLS_EXT;
            PH_LEXT:    w_class = CLS_EXT;
            PH_VALUE:   w_class = CLS_VALUE;
            PH_PAYLOAD: w_class = CLS_PAYLOAD;
            default:    w_class = CLS_IGNORE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_HEADER;
            r_hdr_cnt     <= '0;
            r_token_left  <= '0;
            r_ext_left    <= '0;
            r_delta_code  <= '0;
            r_length_code <= '0;
            r_ext_acc     <= '0;
            r_opt_num     <= '0;
            r_value_left  <= '0;
            r_hdr         <= '0;
            r_err         <= '0;
            r_cur_len     <= '0;
        end else if (w_in_fire) begin
            if (w_last) begin
                // message done: start over at the header
                r_phase       <= PH_HEADER;
                r_hdr_cnt     <= '0;
                r_token_left  <= '0;
                r_ext_left    <= '0;
                r_delta_code  <= '0;
                r_length_code <= '0;
                r_ext_acc     <= '0;
                r_opt_num     <= '0;
                r_value_left  <= '0;
                r_hdr         <= '0;
                r_err         <= '0;
                r_cur_len     <= '0;
            end else begin
                r_phase       <= n_phase;
                r_hdr_cnt     <= n_hdr_cnt;
                r_token_left  <= n_token_left;
                r_ext_left    <= n_ext_left;
                r_delta_code  <= n_delta_code;
                r_length_code <= n_length_code;
                r_ext_acc     <= n_ext_acc;
                r_opt_num     <= n_opt_num;
                r_value_left  <= n_value_left;
                r_hdr         <= n_hdr;
                r_err         <= n_err;
                r_cur_len     <= n_cur_len;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_in_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_out.byte_class     <= w_class;
            r_out.byte_out       <= w_b;
            r_out.version        <= n_hdr[31:30];
            r_out.msg_type       <= n_hdr[29:28];
            r_out.token_len      <= n_hdr[27:24];
            r_out.code           <= n_hdr[23:16];
            r_out.msg_id         <= n_hdr[15:0];
            r_out.option_number  <= n_opt_num;
            r_out.option_length  <= n_cur_len;
            r_out.end_of_message <= w_last;
            r_out.errors         <= n_err;
        end
    end

endmodule

// ===== verif/tb_coap_message_parser.sv =====
`timescale 1ns / 1ps

module tb_coap_message_parser;
    import coap_pkg::*;

    localparam int TOKEN_LIMIT  = 8;
    localparam int HOLD_CYCLES  = 200;
    localparam int TARGET_BYTES = 400;
    localparam int DRAIN_CYCLES = 10;
    localparam int CYCLE_LIMIT  = 200000;

    class coap_scoreboard;
        t_phase      stage;
        logic [2:0]  hdr_idx;
        logic [3:0]  tok_left;
        logic [1:0]  ext_left;
        logic [3:0]  dnib;
        logic [3:0]  lnib;
        logic [15:0] ext_acc;
        logic [15:0] opt_num;
        logic [16:0] val_left;
        logic [16:0] opt_len;
        logic [31:0] hdr_word;
        logic [4:0]  err_bits;
        t_coap_out   parsed_words[$];
        int          mismatches;

        function new();
            mismatches = 0;
            restart();
        endfunction

        function void restart();
            stage    = PH_HEADER;
            hdr_idx  = '0;
            tok_left = '0;
            ext_left = '0;
            dnib     = '0;
            lnib     = '0;
            ext_acc  = '0;
            opt_num  = '0;
            val_left = '0;
            opt_len  = '0;
            hdr_word = '0;
            err_bits = '0;
        endfunction

        function logic [16:0] ext_sum(logic [3:0] nib);
            if (nib == NIB_EXT8) begin
                return EXT8_OFS + ext_acc[7:0];
            end
            return EXT16_OFS + ext_acc;
        endfunction

        function void take_length(logic [16:0] len);
            opt_len  = len;
            val_left = len;
            stage    = (len != 0) ? PH_VALUE : PH_OPTHDR;
        endfunction

        function void take_delta(logic [16:0] delta);
            logic [17:0] sum;
            sum = opt_num + delta;
            // saturate the option number
            if (sum > 18'd65535) begin
                sum = 18'd65535;
                err_bits[ERR_FORMAT] = 1'b1;
            end
            opt_num = sum[15:0];
            if (lnib >= NIB_EXT8) begin
                stage    = PH_LEXT;
                ext_left = (lnib == NIB_EXT8) ? 2'd1 : 2'd2;
                ext_acc  = '0;
            end else begin
                take_length({13'd0, lnib});
            end
        endfunction

        function void note_byte(t_coap_in w);
            t_coap_out  want;
            logic [7:0] b;
            logic [2:0] cls;
            logic       hdr_done;
            b        = w.data_byte;
            cls      = CLS_IGNORE;
            hdr_done = 1'b0;
            case (stage)
                PH_HEADER: begin
                    cls = CLS_HEADER;
                    hdr_word = hdr_word | (32'(b) << (24 - 8 * hdr_idx));
                    if (hdr_idx == 0) begin
                        if (b[7:6] != COAP_VER) err_bits[ERR_VERSION] = 1'b1;
                        if (b[3:0] > TOKEN_LIMIT) err_bits[ERR_TOKEN] = 1'b1;
                    end
                    if (hdr_idx >= 3) begin
                        hdr_done = 1'b1;
                        tok_left = hdr_word[27:24];
                        stage    = (tok_left != 0) ? PH_TOKEN : PH_OPTHDR;
                        hdr_idx  = '0;
                    end else begin
                        hdr_idx++;
                        if (w.last) err_bits[ERR_FORMAT] = 1'b1;
                    end
                end
                PH_TOKEN: begin
                    cls = CLS_TOKEN;
                    if (tok_left != 0) tok_left--;
                    if (tok_left == 0) stage = PH_OPTHDR;
                end
                PH_OPTHDR: begin
                    if (b == MARKER_BYTE) begin
                        cls   = CLS_MARKER;
                        stage = PH_PAYLOAD;
                        if (w.last) err_bits[ERR_MARKER] = 1'b1;
                    end else begin
                        cls     = CLS_OPTHDR;
                        dnib    = b[7:4];
                        lnib    = b[3:0];
                        opt_len = (lnib < NIB_EXT8) ? {13'd0, lnib} : 17'd0;
                        if (dnib == NIB_RSVD || lnib == NIB_RSVD) begin
                            err_bits[ERR_MARKER] = 1'b1;
                            stage = PH_IGNORE;
                        end else if (dnib >= NIB_EXT8) begin
                            stage    = PH_DEXT;
                            ext_left = (dnib == NIB_EXT8) ? 2'd1 : 2'd2;
                            ext_acc  = '0;
                        end else begin
                            take_delta({13'd0, dnib});
                        end
                    end
                end
                PH_DEXT, PH_LEXT: begin
                    cls     = CLS_EXT;
                    ext_acc = {ext_acc[7:0], b};
                    if (ext_left != 0) ext_left--;
                    if (ext_left == 0) begin
                        if (stage == PH_DEXT) take_delta(ext_sum(dnib));
                        else take_length(ext_sum(lnib));
                    end
                end
                PH_VALUE: begin
                    cls = CLS_VALUE;
                    if (val_left != 0) val_left--;
                    if (val_left == 0) stage = PH_OPTHDR;
                end
                PH_PAYLOAD: cls = CLS_PAYLOAD;
                default: cls = CLS_IGNORE;
            endcase

            if (w.last && (stage == PH_DEXT || stage == PH_LEXT || stage == PH_VALUE ||
                           (stage == PH_TOKEN && !hdr_done))) begin
                err_bits[ERR_TRUNC] = 1'b1;
            end

            want.byte_class     = cls;
            want.byte_out       = b;
            want.version        = hdr_word[31:30];
            want.msg_type       = hdr_word[29:28];
            want.token_len      = hdr_word[27:24];
            want.code           = hdr_word[23:16];
            want.msg_id         = hdr_word[15:0];
            want.option_number  = opt_num;
            want.option_length  = opt_len;
            want.end_of_message = w.last;
            want.errors         = err_bits;
            parsed_words.push_back(want);

            if (w.last) restart();
        endfunction

        function void compare(string what, logic [16:0] exp_v, logic [16:0] got_v);
            if (exp_v !== got_v) begin
                mismatches++;
                $display("%0t: %s mismatch: expected %0h, actual %0h",
                         $time, what, exp_v, got_v);
            end
        endfunction

        function void check_word(t_coap_out got);
            t_coap_out want;
            if (parsed_words.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected word: expected none, actual %h", $time, got);
                return;
            end
            want = parsed_words.pop_front();
            compare("byte_class", want.byte_class, got.byte_class);
            compare("byte_out", want.byte_out, got.byte_out);
            compare("version", want.version, got.version);
            compare("msg_type", want.msg_type, got.msg_type);
            compare("token_len", want.token_len, got.token_len);
            compare("code", want.code, got.code);
            compare("msg_id", want.msg_id, got.msg_id);
            compare("option_number", want.option_number, got.option_number);
            compare("option_length", want.option_length, got.option_length);
            compare("end_of_message", want.end_of_message, got.end_of_message);
            compare("errors", want.errors, got.errors);
        endfunction

        function int pending();
            return parsed_words.size();
        endfunction
    endclass

    logic      i_clk = 1'b0;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_coap_in  i_in_data;
    logic      o_out_valid;
    logic      i_out_ready;
    t_coap_out o_out_data;

    coap_scoreboard sb;
    logic [7:0]     msg_bytes[$];
    int             bytes_sent = 0;
    int             cycle_count = 0;
    bit             tx_idle = 1'b0;
    bit             rx_idle = 1'b0;
    bit             hold_req = 1'b0;
    bit             hold_done = 1'b0;

    coap_message_parser #(
        .MAX_TOKEN(TOKEN_LIMIT)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) sb.note_byte(i_in_data);
            if (o_out_valid && i_out_ready) sb.check_word(o_out_data);
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    // receiver side: random stalls plus the one long hold-off
    initial begin
        int stall_left;
        stall_left = 0;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                stall_left = HOLD_CYCLES;
                hold_req   = 1'b0;
            end
            if (stall_left > 0) begin
                i_out_ready <= 1'b0;
                stall_left--;
            end else begin
                i_out_ready <= 1'b1;
                if (rx_idle && $urandom_range(0, 3) == 0) stall_left = pick_gap();
            end
        end
    end

    task automatic send_byte(logic [7:0] b, logic is_last);
        t_coap_in w;
        int       gap;
        w.data_byte = b;
        w.last      = is_last;
        gap = tx_idle ? pick_gap() : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= w;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic send_message();
        for (int i = 0; i < msg_bytes.size(); i++) begin
            send_byte(msg_bytes[i], i == msg_bytes.size() - 1);
        end
        bytes_sent += msg_bytes.size();
    endtask

    function automatic void build_message();
        int         kind;
        int         tkl;
        int         sel;
        int         vlen;
        int         keep;
        logic [1:0] ver;
        logic [3:0] dn;
        logic [3:0] ln;
        logic [7:0] e;
        bit         cut;
        msg_bytes.delete();
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
            repeat ($urandom_range(1, 10)) msg_bytes.push_back(8'($urandom));
            return;
        end
        ver = COAP_VER;
        if ($urandom_range(0, 7) == 0) ver = 2'($urandom);
        tkl = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 15) : $urandom_range(0, 8);
        msg_bytes.push_back({ver, 2'($urandom), 4'(tkl)});
        repeat (3) msg_bytes.push_back(8'($urandom));
        repeat (tkl) msg_bytes.push_back(8'($urandom));
        cut = 1'b0;
        repeat ($urandom_range(0, 3)) begin
            if (!cut) begin
                sel = $urandom_range(0, 14);
                dn  = (sel < 11) ? 4'($urandom_range(0, 12)) :
                      (sel < 13) ? NIB_EXT8 : (sel < 14) ? NIB_EXT16 : NIB_RSVD;
                sel = $urandom_range(0, 14);
                ln  = (sel < 11) ? 4'($urandom_range(0, 12)) :
                      (sel < 13) ? NIB_EXT8 : (sel < 14) ? NIB_EXT16 : NIB_RSVD;
                msg_bytes.push_back({dn, ln});
                if (dn == NIB_RSVD || ln == NIB_RSVD) begin
                    // everything after a reserved nibble is classed as ignored by the parser
                    repeat ($urandom_range(0, 3)) msg_bytes.push_back(8'($urandom));
                    cut = 1'b1;
                end else begin
                    if (dn == NIB_EXT8) msg_bytes.push_back(8'($urandom));
                    if (dn == NIB_EXT16) repeat (2) msg_bytes.push_back(8'($urandom));
                    if (ln == NIB_EXT16) begin
                        // long value: end the message early, inside it
                        repeat (2) msg_bytes.push_back(8'($urandom));
                        repeat ($urandom_range(0, 3)) msg_bytes.push_back(8'($urandom));
                        cut = 1'b1;
                    end else begin
                        vlen = ln;
                        if (ln == NIB_EXT8) begin
                            e = 8'($urandom_range(0, 5));
                            msg_bytes.push_back(e);
                            vlen = e + 13;
                        end
                        repeat (vlen) msg_bytes.push_back(8'($urandom));
                    end
                end
            end
        end
        if (!cut && $urandom_range(0, 1) == 1) begin
            msg_bytes.push_back(MARKER_BYTE);
            repeat ($urandom_range(0, 6)) msg_bytes.push_back(8'($urandom));
        end
        if (kind == 1) begin
            keep = $urandom_range(1, msg_bytes.size());
            msg_bytes = msg_bytes[0:keep - 1];
        end
    endfunction

    initial begin
        sb = new();
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_data  = '0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // header only: bad version, long token, extreme bytes
        msg_bytes = '{8'hCF, 8'h00, 8'hFF, 8'hFF};
        send_message();
        // short message
        msg_bytes = '{8'h44, 8'h11};
        send_message();
        // token, two-byte delta that saturates, value, marker with no payload
        msg_bytes = '{8'h52, 8'h45, 8'h12, 8'h34, 8'hAA, 8'h55, 8'hE1, 8'hFF, 8'hFF,
                      8'h00, 8'hFF};
        send_message();
        // largest extended length, cut before any value byte
        msg_bytes = '{8'h60, 8'h00, 8'h00, 8'h01, 8'h1E, 8'hFF, 8'hFF};
        send_message();
        // reserved nibble, then an ignored byte
        msg_bytes = '{8'h40, 8'h00, 8'h00, 8'h00, 8'hF3, 8'h12};
        send_message();

        while (bytes_sent < TARGET_BYTES) begin
            if (bytes_sent < 120 || bytes_sent >= 220) begin
                tx_idle = 1'b1;
                rx_idle = 1'b1;
            end else begin
                tx_idle = 1'b0;
                rx_idle = 1'b0;
                if (!hold_done) begin
                    hold_done = 1'b1;
                    hold_req  = 1'b1;
                end
            end
            build_message();
            send_message();
        end
        @(negedge i_clk);
        i_in_valid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/coap_pkg.sv
rtl/core/coap_message_parser.sv
verif/tb_coap_message_parser.sv
